### src/tplm_pkg.sv
// ----------------------------------------------------------------------------
// tplm_pkg
// types and constants shared by the threshold posting-list merge block
// ----------------------------------------------------------------------------
package tplm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCHES = 1'b1;

    localparam logic [1:0] FUNC_DOC_ID = 2'd0;
    localparam logic [1:0] FUNC_END_WORD = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [63:0] doc_id;
    } in_item_t;

    typedef struct packed {
        logic valid_res;
        logic [63:0] doc_id_out;
        logic [7:0] match_count;
        logic overflow;
        logic last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRUNE,
        ST_EMIT,
        ST_CLEAR
    } state_t;

endpackage

### src/threshold_posting_list_merge_core.sv
// ----------------------------------------------------------------------------
// threshold_posting_list_merge_core
// merges posting lists, keeps documents found in enough lists
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready, in_item
//  out     | output    | out_valid / out_ready, out_item
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// a doc id request walks the table, one slot read per cycle from the key/count
// memory, stopping early when the id is already present. end of word walks all
// slots. finish emits each valid slot in turn, stalling on out_ready, then
// clears the valid bits, word count and overflow. reset clears valid bits,
// counters and overflow at once; no clearing pass. the table memory port sets the rate.
module threshold_posting_list_merge_core #(
    parameter int TABLE_DEPTH = tplm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  tplm_pkg::in_item_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output tplm_pkg::out_item_t out_item,
    input  logic cfg_we,
    input  logic [tplm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tplm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tplm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [63:0] key_mem [TABLE_DEPTH];
    logic [7:0] cnt_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [63:0] id_reg, id_next;
    logic [7:0] tw_reg, mm_reg, wd_reg, wd_next;
    logic ovf_reg, ovf_next;
    logic [CW-1:0] free_reg, free_next;
    logic free_ok_reg, free_ok_next;
    logic any_reg, any_next;
    logic rd_ok_reg, rd_ok_next;
    logic [AW-1:0] rd_addr_reg, rd_addr;
    logic [63:0] rd_key_reg;
    logic [7:0] rd_cnt_reg;
    logic we;
    logic [AW-1:0] wa;
    logic [63:0] wkey;
    logic [7:0] wcnt;
    logic wkey_en;
    out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [AW-1:0] nxt_valid_idx;
    logic nxt_valid_found;
    logic nxt_more;
    logic signed [9:0] bound;
    logic in_acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item = out_reg;
    assign rd_addr = idx_reg[AW-1:0];
    assign bound = $signed({2'b00, wd_reg}) + $signed({2'b00, mm_reg})
                 - $signed({2'b00, tw_reg});

    // memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cnt_mem[wa] <= wcnt;
            if (wkey_en)
                key_mem[wa] <= wkey;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // lowest valid slot at or above idx, for emit; nxt_more if another follows
    always_comb
    begin
        nxt_valid_found = 1'b0;
        nxt_more = 1'b0;
        nxt_valid_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (i >= int'(idx_reg)))
            begin
                nxt_more = nxt_valid_found;
                nxt_valid_found = 1'b1;
                nxt_valid_idx = AW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            wd_reg <= '0;
            ovf_reg <= 1'b0;
            tw_reg <= 8'd1;
            mm_reg <= 8'd1;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            free_ok_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            any_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            wd_reg <= wd_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            free_ok_reg <= free_ok_next;
            rd_ok_reg <= rd_ok_next;
            any_reg <= any_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TOTAL_WORDS: tw_reg <= cfg_data;
                    REG_MIN_MATCHES: mm_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        free_reg <= free_next;
        out_reg <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    unique case (in_item.func)
                        FUNC_DOC_ID: state_next = ST_SCAN;
                        FUNC_END_WORD: state_next = ST_PRUNE;
                        FUNC_FINISH: state_next = ST_EMIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            ST_SCAN:
                if (rd_ok_reg && valid_reg[rd_addr_reg] && rd_key_reg == id_reg)
                    state_next = ST_IDLE;
                else if (rd_ok_reg && 32'(rd_addr_reg) == TABLE_DEPTH - 1)
                    state_next = ST_IDLE;
            ST_PRUNE:
                if (rd_ok_reg && 32'(rd_addr_reg) == TABLE_DEPTH - 1)
                    state_next = ST_IDLE;
            ST_EMIT:
                if (!out_valid_reg || out_ready)
                begin
                    if (!nxt_valid_found)
                        state_next = ST_CLEAR;
                end
            ST_CLEAR:
                state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        valid_next = valid_reg;
        wd_next = wd_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        id_next = id_reg;
        free_next = free_reg;
        free_ok_next = free_ok_reg;
        rd_ok_next = 1'b0;
        any_next = any_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        we = 1'b0;
        wa = rd_addr_reg;
        wkey = id_reg;
        wkey_en = 1'b0;
        wcnt = 8'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                free_ok_next = 1'b0;
                any_next = 1'b0;
                id_next = in_item.doc_id;
                if (in_acc && in_item.func == FUNC_END_WORD && wd_reg != 8'hff)
                    wd_next = wd_reg + 8'd1;
            end
            ST_SCAN:
            begin
                if (32'(idx_reg) < TABLE_DEPTH)
                begin
                    idx_next = idx_reg + CW'(1);
                    rd_ok_next = 1'b1;
                end
                if (rd_ok_reg)
                begin
                    if (valid_reg[rd_addr_reg])
                    begin
                        if (rd_key_reg == id_reg)
                        begin
                            we = 1'b1;
                            wcnt = (rd_cnt_reg == 8'hff) ? 8'hff : rd_cnt_reg + 8'd1;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next = CW'(rd_addr_reg);
                    end
                    if (32'(rd_addr_reg) == TABLE_DEPTH - 1
                        && !(valid_reg[rd_addr_reg] && rd_key_reg == id_reg))
                    begin
                        if (free_ok_next)
                        begin
                            we = 1'b1;
                            wa = free_next[AW-1:0];
                            wkey_en = 1'b1;
                            wcnt = 8'd1;
                            valid_next[free_next[AW-1:0]] = 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                    end
                end
            end
            ST_PRUNE:
            begin
                if (32'(idx_reg) < TABLE_DEPTH)
                begin
                    idx_next = idx_reg + CW'(1);
                    rd_ok_next = 1'b1;
                end
                if (rd_ok_reg && valid_reg[rd_addr_reg]
                    && $signed({2'b00, rd_cnt_reg}) < bound)
                begin
                    valid_next[rd_addr_reg] = 1'b0;
                    we = 1'b1;
                    wcnt = 8'd0;
                end
            end
            ST_EMIT:
            begin
                // after a jump, wait for the registered read of the new slot so the read data is current
                if (!out_valid_reg || out_ready)
                begin
                    if (!nxt_valid_found)
                    begin
                        if (!any_reg)
                        begin
                            out_next = '{valid_res: 1'b0, doc_id_out: 64'd0,
                                         match_count: 8'd0, overflow: ovf_reg,
                                         last: 1'b1};
                            out_valid_next = 1'b1;
                        end
                    end
                    else if (rd_ok_reg && rd_addr_reg == nxt_valid_idx)
                    begin
                        out_next = '{valid_res: 1'b1, doc_id_out: rd_key_reg,
                                     match_count: rd_cnt_reg, overflow: ovf_reg,
                                     last: !nxt_more};
                        out_valid_next = 1'b1;
                        any_next = 1'b1;
                        idx_next = CW'(nxt_valid_idx) + CW'(1);
                    end
                    else
                    begin
                        idx_next = CW'(nxt_valid_idx);
                        rd_ok_next = 1'b1;
                    end
                end
                else
                    rd_ok_next = rd_ok_reg;
            end
            ST_CLEAR:
            begin
                valid_next = '0;
                wd_next = '0;
                ovf_next = 1'b0;
            end
            default: ;
        endcase
    end

    // a stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item.doc_id_out))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> valid_reg == '0 && !ovf_reg)
        else $error("table not cleared after finish");

endmodule
